// File: rtl/core/draw_order_list_defines.svh
// ---------------------------------------------------------------------------
// Draw order list assertion macros
// Shared property shorthands for the draw order list checkers.
// ---------------------------------------------------------------------------
`ifndef DRAW_ORDER_LIST_DEFINES_SVH
`define DRAW_ORDER_LIST_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DOL_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define DOL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dol_pkg.sv
// ---------------------------------------------------------------------------
// Draw order list package
// Request codes, result status codes and controller states.
// ---------------------------------------------------------------------------
package dol_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT       = 3'd0,
        ACT_REMOVE       = 3'd1,
        ACT_SWAP         = 3'd2,
        ACT_FRONT_IF     = 3'd3,
        ACT_FRONT_FORCE  = 3'd4,
        ACT_BEHIND_IF    = 3'd5,
        ACT_BEHIND_FORCE = 3'd6,
        ACT_QUERY        = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_NO_CHANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PASS,
        S_FLUSH,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/draw_order_list.sv
// ---------------------------------------------------------------------------
// Draw order list
// Ordered list of object ids held in one synchronous RAM, edited in place.
// ---------------------------------------------------------------------------
// Request words enter on i_valid/o_ready: action, two ids and an insert slot.
// Every request returns exactly one result word on o_valid/i_ready: status,
// first position of sprite_a afterwards and the new entry count.
// One request is handled at a time. The list RAM has a single read and a
// single write port with a registered read; it sets the order of work:
//   - search pass: reads every entry once, finds first copies
//   - decide: picks the status and the edit to make
//   - edit pass (not for query or refused requests): streams every
//     entry through once, then a flush of the held word, and an append
//     where no entry triggered the insert; then the result register loads
// The next request word is taken only in the idle state.
// The result sits in an output register; a new request is accepted while
// it waits, and the block holds in its done state only when a second result
// is ready before the first has been taken.
// Reset empties the list (count zero) and drops any pending result. RAM
// contents are not cleared; entries at or past the count are never read.
// ---------------------------------------------------------------------------
module draw_order_list #(
    parameter int LIST_DEPTH = 64,
    parameter int ID_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic [15:0]       i_sprite_a,
    input  logic [15:0]       i_sprite_b,
    input  logic signed [6:0] i_position,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [5:0]        o_found_position,
    output logic [6:0]        o_entry_count
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int KB = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

    // list RAM
    logic [ID_BITS-1:0] r_mem [LIST_DEPTH];
    logic [ID_BITS-1:0] r_rdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ID_BITS-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // control state
    dol_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_dv, n_dv;
    logic            r_hold_v, n_hold_v;
    logic            r_ovld, n_ovld;

    // request and working registers
    dol_pkg::t_action   r_act, n_act;
    logic [ID_BITS-1:0] r_a, n_a;
    logic [ID_BITS-1:0] r_b, n_b;
    logic [6:0]         r_pos, n_pos;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic [AW-1:0]      r_di, n_di;
    logic               r_ha, n_ha;
    logic [AW-1:0]      r_ia, n_ia;
    logic               r_hb, n_hb;
    logic [AW-1:0]      r_ib, n_ib;
    dol_pkg::t_status   r_status, n_status;
    logic               r_drop, n_drop;
    logic               r_swap, n_swap;
    logic               r_ins, n_ins;
    logic               r_at_b, n_at_b;
    logic               r_at_slot, n_at_slot;
    logic               r_after, n_after;
    logic [AW-1:0]      r_slot, n_slot;
    logic [CW-1:0]      r_wr, n_wr;
    logic [ID_BITS-1:0] r_hold, n_hold;
    logic               r_fnd_v, n_fnd_v;
    logic [AW-1:0]      r_found, n_found;
    dol_pkg::t_status   r_o_status, n_o_status;
    logic [5:0]         r_o_found, n_o_found;
    logic [6:0]         r_o_count, n_o_count;

    // helpers
    logic [ID_BITS-1:0] w_id_a, w_id_b;
    logic               w_scan_end;
    logic               w_eq_a, w_eq_b;
    logic               w_full;
    logic               w_slot_ok;
    dol_pkg::t_status   w_dec_status;
    logic               w_dec_pass;
    logic               w_dec_drop, w_dec_swap, w_dec_ins;
    logic               w_dec_at_b, w_dec_at_slot, w_dec_after;
    logic [ID_BITS-1:0] w_e0, w_e1;
    logic [1:0]         w_k;
    logic               w_ins_hit;
    logic [ID_BITS-1:0] w_c0, w_c1;
    logic [1:0]         w_cnt;
    logic               w_cand_v;
    logic [ID_BITS-1:0] w_cand;

    always_comb begin
        w_id_a = '0;
        w_id_b = '0;
        w_id_a[KB-1:0] = i_sprite_a[KB-1:0];
        w_id_b[KB-1:0] = i_sprite_b[KB-1:0];
    end

    assign w_scan_end = (r_rd_idx == r_count) && !r_dv;
    assign w_eq_a     = (r_rdata == r_a);
    assign w_eq_b     = (r_rdata == r_b);
    assign w_full     = (r_count == FULL_CNT);
    assign w_slot_ok  = !r_pos[6] && (PW'(r_pos[5:0]) < PW'(r_count));

    // request decode after the search pass
    always_comb begin
        w_dec_status  = dol_pkg::STS_OK;
        w_dec_pass    = 1'b0;
        w_dec_drop    = 1'b0;
        w_dec_swap    = 1'b0;
        w_dec_ins     = 1'b0;
        w_dec_at_b    = 1'b0;
        w_dec_at_slot = 1'b0;
        w_dec_after   = 1'b0;
        case (r_act)
            dol_pkg::ACT_INSERT: begin
                if (w_full) begin
                    w_dec_status = dol_pkg::STS_FULL;
                end else begin
                    w_dec_pass    = 1'b1;
                    w_dec_ins     = 1'b1;
                    w_dec_at_slot = w_slot_ok;
                end
            end
            dol_pkg::ACT_REMOVE: begin
                if (!r_ha) begin
                    w_dec_status = dol_pkg::STS_NOT_FOUND;
                end else begin
                    w_dec_pass = 1'b1;
                    w_dec_drop = 1'b1;
                end
            end
            dol_pkg::ACT_SWAP: begin
                if (!r_ha && !r_hb) begin
                    w_dec_status = dol_pkg::STS_NOT_FOUND;
                end else begin
                    w_dec_pass = 1'b1;
                    w_dec_swap = 1'b1;
                end
            end
            dol_pkg::ACT_FRONT_IF, dol_pkg::ACT_BEHIND_IF: begin
                if (!r_ha || !r_hb) begin
                    w_dec_status = dol_pkg::STS_NOT_FOUND;
                end else if ((r_act == dol_pkg::ACT_FRONT_IF) ? (r_ia <= r_ib)
                                                              : (r_ia >= r_ib)) begin
                    w_dec_status = dol_pkg::STS_NO_CHANGE;
                end else begin
                    w_dec_pass  = 1'b1;
                    w_dec_drop  = 1'b1;
                    w_dec_ins   = 1'b1;
                    w_dec_at_b  = 1'b1;
                    w_dec_after = (r_act == dol_pkg::ACT_BEHIND_IF);
                end
            end
            dol_pkg::ACT_FRONT_FORCE, dol_pkg::ACT_BEHIND_FORCE: begin
                if (!r_hb) begin
                    w_dec_status = dol_pkg::STS_NOT_FOUND;
                end else if (r_a == r_b) begin
                    w_dec_status = dol_pkg::STS_NO_CHANGE;
                end else if (!r_ha && w_full) begin
                    w_dec_status = dol_pkg::STS_FULL;
                end else begin
                    w_dec_pass  = 1'b1;
                    w_dec_drop  = 1'b1;
                    w_dec_ins   = 1'b1;
                    w_dec_at_b  = 1'b1;
                    w_dec_after = (r_act == dol_pkg::ACT_BEHIND_FORCE);
                end
            end
            dol_pkg::ACT_QUERY: begin
                if (!r_ha) begin
                    w_dec_status = dol_pkg::STS_NOT_FOUND;
                end
            end
            default: begin
                w_dec_status = dol_pkg::STS_OK;
            end
        endcase
    end

    // edit pass: each old entry yields zero, one or two new entries
    always_comb begin
        w_e0      = r_rdata;
        w_e1      = r_rdata;
        w_k       = 2'd1;
        w_ins_hit = 1'b0;
        if (r_swap) begin
            w_e0 = w_eq_a ? r_b : (w_eq_b ? r_a : r_rdata);
        end else if (r_drop && w_eq_a) begin
            w_k = 2'd0;
        end else if (r_ins && r_at_b && w_eq_b) begin
            w_k       = 2'd2;
            w_e0      = r_after ? r_rdata : r_a;
            w_e1      = r_after ? r_a : r_rdata;
            w_ins_hit = 1'b1;
        end else if (r_ins && r_at_slot && (r_di == r_slot)) begin
            w_k       = 2'd2;
            w_e0      = r_a;
            w_e1      = r_rdata;
            w_ins_hit = 1'b1;
        end
        if (!r_dv) begin
            w_k       = 2'd0;
            w_ins_hit = 1'b0;
        end
        // held word goes out first
        if (r_hold_v) begin
            w_c0  = r_hold;
            w_c1  = w_e0;
            w_cnt = w_k + 2'd1;
        end else begin
            w_c0  = w_e0;
            w_c1  = w_e1;
            w_cnt = w_k;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dol_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = dol_pkg::S_SCAN;
                end
            end
            dol_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = dol_pkg::S_DECIDE;
                end
            end
            dol_pkg::S_DECIDE: begin
                n_state = w_dec_pass ? dol_pkg::S_PASS : dol_pkg::S_DONE;
            end
            dol_pkg::S_PASS: begin
                if (w_scan_end) begin
                    n_state = dol_pkg::S_FLUSH;
                end
            end
            dol_pkg::S_FLUSH: begin
                if (!r_hold_v && !r_ins) begin
                    n_state = dol_pkg::S_DONE;
                end
            end
            dol_pkg::S_DONE: begin
                if (!r_ovld || i_ready) begin
                    n_state = dol_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dol_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count    = r_count;
        n_dv       = r_dv;
        n_hold_v   = r_hold_v;
        n_ovld     = r_ovld;
        n_act      = r_act;
        n_a        = r_a;
        n_b        = r_b;
        n_pos      = r_pos;
        n_rd_idx   = r_rd_idx;
        n_di       = r_di;
        n_ha       = r_ha;
        n_ia       = r_ia;
        n_hb       = r_hb;
        n_ib       = r_ib;
        n_status   = r_status;
        n_drop     = r_drop;
        n_swap     = r_swap;
        n_ins      = r_ins;
        n_at_b     = r_at_b;
        n_at_slot  = r_at_slot;
        n_after    = r_after;
        n_slot     = r_slot;
        n_wr       = r_wr;
        n_hold     = r_hold;
        n_fnd_v    = r_fnd_v;
        n_found    = r_found;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_count  = r_o_count;
        w_re       = 1'b0;
        w_raddr    = r_rd_idx[AW-1:0];
        w_cand_v   = 1'b0;
        w_cand     = w_c0;

        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end

        // sequential read of entries 0 .. count-1
        if ((r_state == dol_pkg::S_SCAN) || (r_state == dol_pkg::S_PASS)) begin
            if (r_rd_idx != r_count) begin
                w_re     = 1'b1;
                n_rd_idx = r_rd_idx + 1'b1;
                n_dv     = 1'b1;
                n_di     = r_rd_idx[AW-1:0];
            end else begin
                n_dv = 1'b0;
            end
        end

        case (r_state)
            dol_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_act    = dol_pkg::t_action'(i_action);
                    n_a      = w_id_a;
                    n_b      = w_id_b;
                    n_pos    = i_position;
                    n_rd_idx = '0;
                    n_dv     = 1'b0;
                    n_ha     = 1'b0;
                    n_ia     = '0;
                    n_hb     = 1'b0;
                    n_ib     = '0;
                end
            end
            dol_pkg::S_SCAN: begin
                if (r_dv) begin
                    if (!r_ha && w_eq_a) begin
                        n_ha = 1'b1;
                        n_ia = r_di;
                    end
                    if (!r_hb && w_eq_b) begin
                        n_hb = 1'b1;
                        n_ib = r_di;
                    end
                end
            end
            dol_pkg::S_DECIDE: begin
                n_status  = w_dec_status;
                n_drop    = w_dec_drop;
                n_swap    = w_dec_swap;
                n_ins     = w_dec_ins;
                n_at_b    = w_dec_at_b;
                n_at_slot = w_dec_at_slot;
                n_after   = w_dec_after;
                n_slot    = AW'(r_pos[5:0]);
                n_rd_idx  = '0;
                n_dv      = 1'b0;
                n_wr      = '0;
                n_hold_v  = 1'b0;
                n_fnd_v   = 1'b0;
                n_found   = w_dec_pass ? '0 : r_ia;
            end
            dol_pkg::S_PASS: begin
                w_cand_v = (w_cnt != 2'd0);
                w_cand   = w_c0;
                n_hold_v = (w_cnt >= 2'd2);
                n_hold   = w_c1;
                if (w_ins_hit) begin
                    n_ins = 1'b0;
                end
            end
            dol_pkg::S_FLUSH: begin
                if (r_hold_v) begin
                    w_cand_v = 1'b1;
                    w_cand   = r_hold;
                    n_hold_v = 1'b0;
                end else if (r_ins) begin
                    // nothing triggered the insert: append
                    w_cand_v = 1'b1;
                    w_cand   = r_a;
                    n_ins    = 1'b0;
                end else begin
                    n_count = r_wr;
                end
            end
            dol_pkg::S_DONE: begin
                if (!r_ovld || i_ready) begin
                    n_ovld     = 1'b1;
                    n_o_status = r_status;
                    n_o_found  = 6'(r_found);
                    n_o_count  = 7'(r_count);
                end
            end
            default: begin
                n_dv = 1'b0;
            end
        endcase

        // write-back of the new list, tracking the first copy of A
        if (w_cand_v) begin
            n_wr = r_wr + 1'b1;
            if (!r_fnd_v && (w_cand == r_a)) begin
                n_fnd_v = 1'b1;
                n_found = r_wr[AW-1:0];
            end
        end
    end

    assign w_we    = w_cand_v;
    assign w_waddr = r_wr[AW-1:0];
    assign w_wdata = w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dol_pkg::S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_hold_v <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_hold_v <= n_hold_v;
            r_ovld   <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_a        <= n_a;
        r_b        <= n_b;
        r_pos      <= n_pos;
        r_rd_idx   <= n_rd_idx;
        r_di       <= n_di;
        r_ha       <= n_ha;
        r_ia       <= n_ia;
        r_hb       <= n_hb;
        r_ib       <= n_ib;
        r_status   <= n_status;
        r_drop     <= n_drop;
        r_swap     <= n_swap;
        r_ins      <= n_ins;
        r_at_b     <= n_at_b;
        r_at_slot  <= n_at_slot;
        r_after    <= n_after;
        r_slot     <= n_slot;
        r_wr       <= n_wr;
        r_hold     <= n_hold;
        r_fnd_v    <= n_fnd_v;
        r_found    <= n_found;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_count  <= n_o_count;
    end

    assign o_ready          = (r_state == dol_pkg::S_IDLE);
    assign o_valid          = r_ovld;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_entry_count    = r_o_count;

endmodule

// File: rtl/core/dol_checker.sv
// ---------------------------------------------------------------------------
// Draw order list checker
// Port-level properties of the draw order list, bound to the top level.
// ---------------------------------------------------------------------------
`include "draw_order_list_defines.svh"

module dol_checker #(
    parameter int LIST_DEPTH = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [6:0] o_entry_count
);

    localparam logic [6:0] FULL_CNT = 7'(LIST_DEPTH);

    // one request in flight: busy straight after an accept
    `DOL_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready,
        "request accepted while previous still in progress")

    // a full refusal reports a full list
    `DOL_ASSERT_IMPL(a_full_count, o_valid && (o_status == dol_pkg::STS_FULL),
        o_entry_count == FULL_CNT, "full status with list not full")

    // stalled result word holds
    `DOL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_status) && $stable(o_entry_count),
        "result word changed while stalled")

endmodule

bind draw_order_list dol_checker #(.LIST_DEPTH(LIST_DEPTH)) u_dol_checker (.*);

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// Draw order list testbench
// Drives request words through draw_order_list and checks every result word
// against a shadow copy of the list kept in the bench. Directed edge cases
// come first, then filling to capacity and randomised traffic at several
// list sizes, with random gaps on the request side and random stalls on the
// result side. One phase holds the result side off for a long stretch, and
// another lets the block drain completely before it goes on.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 300;

    typedef struct {
        dol_pkg::t_action act;
        logic [15:0]      id_a;
        logic [15:0]      id_b;
        dol_pkg::t_status status;
        logic [5:0]       found_pos;
        logic [6:0]       count;
    } t_order_outcome;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_ready;
    logic [2:0]        i_action   = '0;
    logic [15:0]       i_sprite_a = '0;
    logic [15:0]       i_sprite_b = '0;
    logic signed [6:0] i_position = '0;
    logic              o_valid;
    logic              i_ready    = 1'b0;
    logic [1:0]        o_status;
    logic [5:0]        o_found_position;
    logic [6:0]        o_entry_count;

    logic [15:0]    shadow_ids [0:DEPTH-1];
    int             shadow_len = 0;
    logic [15:0]    id_table [0:DEPTH-1];
    t_order_outcome pending_outcomes [$];

    int err_count     = 0;
    int stall_cycles  = 0;
    int tx_burst_left = 0;
    bit tx_gaps_on    = 1'b1;
    bit rx_stalls_on  = 1'b1;
    int rx_hold_req   = 0;
    int rx_hold_left  = 0;
    int rx_run_left   = 0;
    int rx_stall_left = 0;

    draw_order_list u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_sprite_a       (i_sprite_a),
        .i_sprite_b       (i_sprite_b),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    // ---- shadow list ----------------------------------------------------

    function automatic int first_index(logic [15:0] id);
        for (int i = 0; i < shadow_len; i++) begin
            if (shadow_ids[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic int drop_id(logic [15:0] id);
        int wr;
        int n;
        wr = 0;
        n  = 0;
        for (int rd = 0; rd < shadow_len; rd++) begin
            if (shadow_ids[rd] == id) n++;
            else begin
                shadow_ids[wr] = shadow_ids[rd];
                wr++;
            end
        end
        shadow_len = wr;
        return n;
    endfunction

    function automatic void place_id(logic [15:0] id, int slot);
        if (shadow_len >= DEPTH) return;
        if (slot > shadow_len) slot = shadow_len;
        for (int i = shadow_len; i > slot; i--) shadow_ids[i] = shadow_ids[i-1];
        shadow_ids[slot] = id;
        shadow_len++;
    endfunction

    function automatic void relocate_id(logic [15:0] a, logic [15:0] b, bit after);
        int j;
        void'(drop_id(a));
        j = first_index(b);
        if (j < 0) j = 0;
        place_id(a, after ? j + 1 : j);
    endfunction

    function automatic t_order_outcome shadow_apply(dol_pkg::t_action act, logic [15:0] a,
                                                    logic [15:0] b,
                                                    logic signed [6:0] pos);
        t_order_outcome res;
        int ia;
        int ib;
        int p;
        p  = pos;
        ia = first_index(a);
        ib = first_index(b);
        res.act    = act;
        res.id_a   = a;
        res.id_b   = b;
        res.status = dol_pkg::STS_OK;
        case (act)
            dol_pkg::ACT_INSERT: begin
                if (shadow_len >= DEPTH) res.status = dol_pkg::STS_FULL;
                else if (p < 0 || p >= shadow_len) place_id(a, shadow_len);
                else place_id(a, p);
            end
            dol_pkg::ACT_REMOVE: begin
                if (drop_id(a) == 0) res.status = dol_pkg::STS_NOT_FOUND;
            end
            dol_pkg::ACT_SWAP: begin
                if (ia < 0 && ib < 0) res.status = dol_pkg::STS_NOT_FOUND;
                else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        if (shadow_ids[i] == a) shadow_ids[i] = b;
                        else if (shadow_ids[i] == b) shadow_ids[i] = a;
                    end
                end
            end
            dol_pkg::ACT_FRONT_IF, dol_pkg::ACT_BEHIND_IF: begin
                if (ia < 0 || ib < 0) res.status = dol_pkg::STS_NOT_FOUND;
                else if (act == dol_pkg::ACT_FRONT_IF ? (ia <= ib) : (ia >= ib))
                    res.status = dol_pkg::STS_NO_CHANGE;
                else relocate_id(a, b, act == dol_pkg::ACT_BEHIND_IF);
            end
            dol_pkg::ACT_FRONT_FORCE, dol_pkg::ACT_BEHIND_FORCE: begin
                if (ib < 0) res.status = dol_pkg::STS_NOT_FOUND;
                else if (a == b) res.status = dol_pkg::STS_NO_CHANGE;
                else if (ia < 0 && shadow_len >= DEPTH) res.status = dol_pkg::STS_FULL;
                else relocate_id(a, b, act == dol_pkg::ACT_BEHIND_FORCE);
            end
            default: begin
                if (ia < 0) res.status = dol_pkg::STS_NOT_FOUND;
            end
        endcase
        ia = first_index(a);
        res.found_pos = (ia < 0) ? 6'd0 : 6'(ia);
        res.count     = 7'(shadow_len);
        return res;
    endfunction

    // ---- request side ---------------------------------------------------

    task automatic send_word(dol_pkg::t_action act, logic [15:0] a, logic [15:0] b,
                             logic signed [6:0] pos);
        int gap;
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_action   <= act;
        i_sprite_a <= a;
        i_sprite_b <= b;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.insert(pending_outcomes.size(), shadow_apply(act, a, b, pos));
        if (tx_gaps_on) begin
            tx_burst_left--;
            if (tx_burst_left <= 0) begin
                tx_burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_id(int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'($urandom);
        if (r < 10) return 16'h0000;
        if (r < 12) return 16'hFFFF;
        return id_table[$urandom_range(0, spread - 1)];
    endfunction

    function automatic logic [15:0] pick_listed(int spread);
        if (shadow_len > 0 && $urandom_range(0, 99) < 65)
            return shadow_ids[$urandom_range(0, shadow_len - 1)];
        return pick_id(spread);
    endfunction

    function automatic logic signed [6:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return -7'sd1;
        if (r < 25) return 7'($urandom_range(0, 63));
        return 7'($urandom_range(0, (shadow_len > 63) ? 63 : shadow_len));
    endfunction

    task automatic random_request(int spread, int target);
        dol_pkg::t_action act;
        int r;
        r = $urandom_range(0, 99);
        if (r < ((shadow_len < target) ? 40 : 12)) act = dol_pkg::ACT_INSERT;
        else act = dol_pkg::t_action'($urandom_range(1, 7));
        if (act == dol_pkg::ACT_INSERT)
            send_word(act, pick_id(spread), pick_listed(spread), pick_pos());
        else
            send_word(act, pick_listed(spread), pick_listed(spread), pick_pos());
    endtask

    // ---- tests ----------------------------------------------------------

    task automatic test_directed();
        send_word(dol_pkg::ACT_QUERY,        16'h1234, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_REMOVE,       16'h0000, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_SWAP,         16'h0001, 16'h0002, 7'sd0);
        send_word(dol_pkg::ACT_FRONT_FORCE,  16'h0005, 16'h0006, 7'sd0);
        send_word(dol_pkg::ACT_INSERT,       16'h0000, 16'h0000, -7'sd1);
        send_word(dol_pkg::ACT_INSERT,       16'hFFFF, 16'h0000, 7'sd63);
        send_word(dol_pkg::ACT_INSERT,       16'h0001, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_INSERT,       16'h8000, 16'h0000, 7'sd1);
        send_word(dol_pkg::ACT_INSERT,       16'hFFFF, 16'h0000, 7'sd2);
        send_word(dol_pkg::ACT_QUERY,        16'hFFFF, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_FRONT_IF,     16'h8000, 16'h0001, 7'sd0);
        send_word(dol_pkg::ACT_FRONT_IF,     16'h8000, 16'h0001, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_IF,    16'h0000, 16'hFFFF, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_IF,    16'h8000, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_IF,    16'h4242, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_FRONT_FORCE,  16'hFFFF, 16'h0001, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_FORCE, 16'h2222, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_FORCE, 16'h0003, 16'h0003, 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_FORCE, 16'h0001, 16'h0001, 7'sd0);
        send_word(dol_pkg::ACT_FRONT_FORCE,  16'h0001, 16'h0001, 7'sd0);
        send_word(dol_pkg::ACT_SWAP,         16'h0000, 16'h5555, 7'sd0);
        send_word(dol_pkg::ACT_SWAP,         16'h0001, 16'hFFFF, 7'sd0);
        send_word(dol_pkg::ACT_INSERT,       16'h8000, 16'h0000, 7'(shadow_len));
        send_word(dol_pkg::ACT_REMOVE,       16'h8000, 16'h0000, 7'sd0);
        send_word(dol_pkg::ACT_QUERY,        16'h8000, 16'h0000, 7'sd0);
    endtask

    task automatic test_fill_to_capacity();
        logic [15:0] fresh;
        while (shadow_len < DEPTH)
            send_word(dol_pkg::ACT_INSERT, pick_id(48), 16'h0, pick_pos());
        repeat (3) send_word(dol_pkg::ACT_INSERT, pick_id(48), 16'h0, pick_pos());
        do fresh = 16'($urandom); while (first_index(fresh) >= 0);
        send_word(dol_pkg::ACT_FRONT_FORCE, fresh, shadow_ids[5], 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_FORCE, fresh, shadow_ids[DEPTH-1], 7'sd0);
        send_word(dol_pkg::ACT_BEHIND_FORCE, shadow_ids[0], shadow_ids[DEPTH-1], 7'sd0);
        send_word(dol_pkg::ACT_FRONT_FORCE, shadow_ids[DEPTH-1], shadow_ids[0], 7'sd0);
        repeat (8) begin
            send_word(dol_pkg::t_action'($urandom_range(2, 7)), pick_listed(48),
                      pick_listed(48), pick_pos());
        end
        while (shadow_len > 40)
            send_word(dol_pkg::ACT_REMOVE, pick_listed(48), 16'h0, 7'sd0);
    endtask

    task automatic test_random_mix(int n, int spread, int target);
        repeat (n) random_request(spread, target);
    endtask

    task automatic test_output_hold_off();
        bit gaps_saved;
        gaps_saved = tx_gaps_on;
        tx_gaps_on = 1'b0;
        @(posedge i_clk);
        rx_hold_req = HOLD_CYCLES;
        repeat (12) random_request(32, 32);
        tx_gaps_on = gaps_saved;
    endtask

    task automatic test_drain_pause();
        repeat (10) random_request(16, 20);
        wait_drained();
        repeat (10) random_request(16, 20);
    endtask

    // ---- result side ----------------------------------------------------

    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_run_left > 0) begin
            rx_run_left--;
            i_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else begin
            rx_run_left   = $urandom_range(1, 20);
            rx_stall_left = rx_stalls_on ? $urandom_range(1, 7) : 0;
            i_ready <= 1'b1;
        end
    end

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_order_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                note_error($sformatf("unexpected result word: status %0d pos %0d count %0d",
                                     o_status, o_found_position, o_entry_count));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status || o_found_position !== want.found_pos ||
                    o_entry_count !== want.count) begin
                    note_error($sformatf(
                        "%s a=%h b=%h: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                        want.act.name(), want.id_a, want.id_b, want.status, want.found_pos,
                        want.count, o_status, o_found_position, o_entry_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) id_table[i] = 16'($urandom);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_to_capacity();
        test_random_mix(300, 8, 12);
        test_drain_pause();
        test_random_mix(280, 40, 40);
        test_output_hold_off();
        test_random_mix(250, 64, 64);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_mix(150, 24, 24);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_drain_pause();

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
